>>> rtl/tslb_pkg.sv
// shared types and byte codes for the terminal session line bridge
package tslb_pkg;

  // width of a line byte count, enough for the longest line of 31 bytes
  localparam int CNT_W = 5;
  // jobs held between the classifier and the byte sender
  localparam int QDEPTH = 2;

  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CTRL_R = 8'h12;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [7:0] TN_CMD_LOW  = 8'd250;
  localparam logic [7:0] TN_WILL     = 8'd251;
  localparam logic [7:0] TN_WONT     = 8'd252;
  localparam logic [7:0] TN_DO       = 8'd253;
  localparam logic [7:0] TN_DONT     = 8'd254;
  localparam logic [7:0] TN_IAC      = 8'd255;
  localparam logic [7:0] TN_OPT_ECHO = 8'd1;

  localparam logic SRC_SERIAL  = 1'b0;
  localparam logic DEST_SERIAL = 1'b0;
  localparam logic DEST_NET    = 1'b1;

  typedef enum logic [1:0] {
    TN_PLAIN   = 2'd0,
    TN_GOT_IAC = 2'd1,
    TN_GOT_CMD = 2'd2
  } tn_phase_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_FIX   = 2'd1,
    B_RADDR = 2'd2,
    B_RDATA = 2'd3
  } back_st_t;

  // literal bytes first, then bytes read back from the line store
  typedef struct packed {
    logic [3:0][7:0]  fix_b;
    logic [2:0]       fix_n;
    logic             fix_dest;
    logic [CNT_W-1:0] rd_cnt;
    logic             rd_dest;
  } job_t;

endpackage

>>> rtl/tslb_ram.sv
// generic single write, single read ram with registered read data
module tslb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/tslb_front.sv
// input classifier: line editor, telnet parser, line store writes and job generation
module tslb_front #(
  parameter int LINE_LEN = 32,
  localparam int AW = $clog2(LINE_LEN)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_mode,
  input  logic [7:0]       in_byte,
  input  logic             q_full,
  output logic             push,
  output tslb_pkg::job_t   job,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output logic [7:0]       wr_data,
  input  logic             rd_done
);
  import tslb_pkg::*;

  localparam logic [AW:0] FLUSH_AT = (AW+1)'(LINE_LEN - 1);

  logic [AW-1:0] fill_r, fill_nxt;
  logic          remote_echo_r, remote_echo_nxt;
  tn_phase_t     phase_r, phase_nxt;
  logic [7:0]    held_r, held_nxt;
  logic          rd_pend_r, rd_pend_nxt;

  logic          accept;
  logic          append;
  logic [7:0]    c;
  logic [7:0]    reply;
  logic [AW:0]   nf;

  // a queued job that reads the line store blocks new transfers until it is read out
  assign in_stall = q_full || rd_pend_r;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    job             = '0;
    push            = 1'b0;
    append          = 1'b0;
    c               = in_byte;
    reply           = TN_WONT;
    nf              = '0;
    fill_nxt        = fill_r;
    remote_echo_nxt = remote_echo_r;
    phase_nxt       = phase_r;
    held_nxt        = held_r;
    wr_en           = 1'b0;
    wr_addr         = fill_r;
    wr_data         = in_byte;

    if (accept) begin
      if (in_mode == SRC_SERIAL) begin
        if (!remote_echo_r && in_byte == CH_CTRL_R) begin
          job.fix_b    = {CH_NL, CH_CR, CH_R, CH_CARET};
          job.fix_n    = 3'd4;
          job.fix_dest = DEST_SERIAL;
          job.rd_cnt   = CNT_W'(fill_r);
          job.rd_dest  = DEST_SERIAL;
          push         = 1'b1;
        end else if (!remote_echo_r && (in_byte == CH_DEL || in_byte == CH_BS)) begin
          // erase on an empty line does nothing
          if (fill_r != '0) begin
            fill_nxt     = fill_r - 1'b1;
            job.fix_b    = {CH_NUL, CH_BS, CH_SP, CH_BS};
            job.fix_n    = 3'd3;
            job.fix_dest = DEST_SERIAL;
            push         = 1'b1;
          end
        end else begin
          append = 1'b1;
          if (!remote_echo_r) begin
            job.fix_dest = DEST_SERIAL;
            if (in_byte == CH_CR || in_byte == CH_NL) begin
              c         = CH_NL;
              job.fix_b = {CH_NUL, CH_NUL, CH_NL, CH_CR};
              job.fix_n = 3'd2;
            end else begin
              job.fix_b = {CH_NUL, CH_NUL, CH_NUL, in_byte};
              job.fix_n = 3'd1;
            end
          end
        end
      end else begin
        case (phase_r)
          TN_GOT_IAC: begin
            if (in_byte > TN_CMD_LOW && in_byte != TN_IAC) begin
              held_nxt  = in_byte;
              phase_nxt = TN_GOT_CMD;
            end else begin
              phase_nxt = TN_PLAIN;
            end
          end
          TN_GOT_CMD: begin
            if (held_r == TN_WILL) begin
              if (in_byte == TN_OPT_ECHO) begin
                remote_echo_nxt = 1'b1;
                reply           = TN_DO;
              end else begin
                reply = TN_DONT;
              end
            end else if (held_r == TN_WONT) begin
              if (in_byte == TN_OPT_ECHO) begin
                remote_echo_nxt = 1'b0;
              end
              reply = TN_DONT;
            end else begin
              reply = TN_WONT;
            end
            phase_nxt    = TN_PLAIN;
            job.fix_b    = {CH_NUL, in_byte, reply, TN_IAC};
            job.fix_n    = 3'd3;
            job.fix_dest = DEST_NET;
            push         = 1'b1;
          end
          default: begin
            phase_nxt = TN_PLAIN;
            if (in_byte == TN_IAC) begin
              phase_nxt = TN_GOT_IAC;
            end else begin
              job.fix_dest = DEST_SERIAL;
              push         = 1'b1;
              if (in_byte == CH_NL) begin
                job.fix_b = {CH_NUL, CH_NUL, CH_NL, CH_CR};
                job.fix_n = 3'd2;
              end else begin
                job.fix_b = {CH_NUL, CH_NUL, CH_NUL, in_byte};
                job.fix_n = 3'd1;
              end
            end
          end
        endcase
      end
    end

    if (append) begin
      wr_en   = 1'b1;
      wr_data = c;
      nf      = {1'b0, fill_r} + 1'b1;
      push    = 1'b1;
      if (nf >= FLUSH_AT || remote_echo_r || c == CH_NL) begin
        fill_nxt    = '0;
        job.rd_cnt  = CNT_W'(nf);
        job.rd_dest = DEST_NET;
      end else begin
        fill_nxt = nf[AW-1:0];
      end
    end
  end

  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (rd_done) begin
      rd_pend_nxt = 1'b0;
    end
    if (push && job.rd_cnt != '0) begin
      rd_pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r        <= '0;
      remote_echo_r <= 1'b0;
      phase_r       <= TN_PLAIN;
      held_r        <= '0;
      rd_pend_r     <= 1'b0;
    end else begin
      fill_r        <= fill_nxt;
      remote_echo_r <= remote_echo_nxt;
      phase_r       <= phase_nxt;
      held_r        <= held_nxt;
      rd_pend_r     <= rd_pend_nxt;
    end
  end

endmodule

>>> rtl/tslb_queue.sv
// short job queue between the classifier and the byte sender
module tslb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tslb_pkg::job_t job_in,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output tslb_pkg::job_t job_out
);
  import tslb_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  job_t          slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = cnt_r == CW'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> rtl/tslb_back.sv
// byte sender: plays out one job at a time into the output register
module tslb_back #(
  parameter int LINE_LEN = 32,
  localparam int AW = $clog2(LINE_LEN)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  tslb_pkg::job_t q_job,
  output logic           pop,
  output logic           rd_en,
  output logic [AW-1:0]  rd_addr,
  input  logic [7:0]     rd_data,
  output logic           rd_done,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_dest,
  output logic [7:0]     out_byte,
  output logic           out_last
);
  import tslb_pkg::*;

  back_st_t         st_r, st_nxt;
  job_t             job_r, job_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_dest_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  logic             ld_ok;
  logic             load;
  logic             ld_dest;
  logic [7:0]       ld_byte;
  logic             ld_last;
  logic             fix_end;
  logic             rd_end;

  assign ld_ok   = !out_valid_r || !out_stall;
  assign fix_end = idx_r == (CNT_W'(job_r.fix_n) - CNT_W'(1));
  assign rd_end  = idx_r == (job_r.rd_cnt - CNT_W'(1));
  assign rd_addr = idx_r[AW-1:0];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          st_nxt = (q_job.fix_n != '0) ? B_FIX : B_RADDR;
        end
      end
      B_FIX: begin
        if (ld_ok && fix_end) begin
          st_nxt = (job_r.rd_cnt != '0) ? B_RADDR : B_IDLE;
        end
      end
      B_RADDR: st_nxt = B_RDATA;
      B_RDATA: begin
        if (ld_ok) begin
          st_nxt = rd_end ? B_IDLE : B_RADDR;
        end
      end
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_done = 1'b0;
    load    = 1'b0;
    ld_dest = job_r.fix_dest;
    ld_byte = job_r.fix_b[idx_r[1:0]];
    ld_last = 1'b0;
    job_nxt = job_r;
    idx_nxt = idx_r;
    case (st_r)
      B_IDLE: begin
        pop     = !q_empty;
        job_nxt = q_job;
        idx_nxt = '0;
      end
      B_FIX: begin
        if (ld_ok) begin
          load    = 1'b1;
          ld_last = fix_end && job_r.rd_cnt == '0;
          idx_nxt = fix_end ? '0 : idx_r + 1'b1;
        end
      end
      B_RADDR: rd_en = 1'b1;
      B_RDATA: begin
        // ram output holds while stalled since no new read is issued
        if (ld_ok) begin
          load    = 1'b1;
          ld_dest = job_r.rd_dest;
          ld_byte = rd_data;
          ld_last = rd_end;
          rd_done = rd_end;
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    idx_r <= idx_nxt;
    if (load) begin
      out_dest_r <= ld_dest;
      out_byte_r <= ld_byte;
      out_last_r <= ld_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_dest  = out_dest_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

>>> rtl/terminal_session_line_bridge.sv
// top level of the terminal session line bridge
// in_* carries one byte per transfer: in_mode 0 from the serial terminal,
// 1 from the network. out_* carries the bytes it causes, out_dest 0 to the
// serial terminal, 1 to the network, with out_last on the final byte of
// each input. Inputs that cause nothing (telnet prefixes, erase on an empty
// line) give no output transfer at all.
// The front end classifies each accepted byte, writes the line store and
// queues a job; the back end plays jobs out of a two-entry queue.
// The first byte of an input passes through the queue, the back end job register
// and the output register. Literal bytes follow one per cycle while out_stall is low;
// each byte read back from the line store needs a ram read and then the output
// load. A line-store-reading job blocks new input transfers until its last stored
// byte has been read.
// Reset (rst_n low, synchronous) empties the line, selects local echo and
// clears the telnet parser and the queue; line store contents are not cleared.
// A stalled output byte holds; the queue keeps accepting input until full or a store read is pending.
module terminal_session_line_bridge #(
  parameter int LINE_LEN = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_mode,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_dest,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import tslb_pkg::*;

  localparam int AW = $clog2(LINE_LEN);

  logic          push;
  job_t          push_job;
  logic          q_full;
  logic          q_empty;
  logic          pop;
  job_t          q_job;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          rd_done;

  tslb_front #(.LINE_LEN(LINE_LEN)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_done  (rd_done)
  );

  tslb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (push_job),
    .full    (q_full),
    .pop     (pop),
    .empty   (q_empty),
    .job_out (q_job)
  );

  tslb_ram #(.WIDTH(8), .DEPTH(LINE_LEN)) u_line_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tslb_back #(.LINE_LEN(LINE_LEN)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .pop       (pop),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .rd_done   (rd_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_dest  (out_dest),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

>>> rtl/tslb_checker.sv
// port level checks for the terminal session line bridge, bound to the top level
module tslb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_mode,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_dest,
  input logic [7:0] out_byte,
  input logic       out_last
);

  // reset leaves no pending output byte
  a_rst_out_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // reset empties the queue and drops any store read lock
  a_rst_in_open: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_mode) && $stable(in_byte))
    else $error("input transfer changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte) && $stable(out_dest) && $stable(out_last))
    else $error("output payload changed while stalled");

endmodule

bind terminal_session_line_bridge tslb_checker u_tslb_checker (.*);

>>> dv/tb_terminal_session_line_bridge.sv
// testbench for the terminal session line bridge: line editing, echo negotiation, forwarding
module tb_terminal_session_line_bridge;
  import tslb_pkg::*;

  localparam int LINE_LEN = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int END_WAIT = 100;
  localparam logic SRC_NET = 1'b1;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
  } tx_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_mode = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_dest;
  logic [7:0] out_byte;
  logic       out_last;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_count = 0;
  int cycle_count = 0;

  // predicted bridge state
  logic [7:0] line_buf [32];
  int         line_fill = 0;
  logic       remote_echo = 1'b0;
  tn_phase_t  tn_phase = TN_PLAIN;
  logic [7:0] held_cmd = 8'h00;
  tx_byte_t   pending_tx [$];
  tx_byte_t   burst_tx [$];

  terminal_session_line_bridge #(.LINE_LEN(LINE_LEN)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mode(in_mode),
    .in_byte(in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_dest(out_dest),
    .out_byte(out_byte),
    .out_last(out_last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_terminal_session_line_bridge: errors");
      $finish;
    end
  end

  function automatic void emit(logic dest, logic [7:0] b);
    tx_byte_t t;
    t.dest = dest;
    t.data = b;
    t.last = 1'b0;
    burst_tx.push_back(t);
  endfunction

  function automatic void edit_serial_byte(logic [7:0] c);
    logic [7:0] ch;
    ch = c;
    if (!remote_echo) begin
      if (ch == CH_CTRL_R) begin
        emit(DEST_SERIAL, CH_CARET);
        emit(DEST_SERIAL, CH_R);
        emit(DEST_SERIAL, CH_CR);
        emit(DEST_SERIAL, CH_NL);
        for (int i = 0; i < line_fill; i++) emit(DEST_SERIAL, line_buf[5'(i)]);
        return;
      end
      if (ch == CH_DEL || ch == CH_BS) begin
        if (line_fill != 0) begin
          line_fill--;
          emit(DEST_SERIAL, CH_BS);
          emit(DEST_SERIAL, CH_SP);
          emit(DEST_SERIAL, CH_BS);
        end
        return;
      end
      if (ch == CH_CR) ch = CH_NL;
      if (ch == CH_NL) begin
        emit(DEST_SERIAL, CH_CR);
        emit(DEST_SERIAL, CH_NL);
      end else begin
        emit(DEST_SERIAL, ch);
      end
    end
    line_buf[5'(line_fill)] = ch;
    line_fill++;
    if (line_fill >= LINE_LEN - 1 || remote_echo || ch == CH_NL) begin
      for (int i = 0; i < line_fill; i++) emit(DEST_NET, line_buf[5'(i)]);
      line_fill = 0;
    end
  endfunction

  function automatic void parse_network_byte(logic [7:0] c);
    logic [7:0] answer;
    case (tn_phase)
      TN_GOT_IAC: begin
        if (c > TN_CMD_LOW && c < TN_IAC) begin
          held_cmd = c;
          tn_phase = TN_GOT_CMD;
        end else begin
          tn_phase = TN_PLAIN;
        end
      end
      TN_GOT_CMD: begin
        if (held_cmd == TN_WILL) begin
          if (c == TN_OPT_ECHO) begin
            remote_echo = 1'b1;
            answer = TN_DO;
          end else begin
            answer = TN_DONT;
          end
        end else if (held_cmd == TN_WONT) begin
          if (c == TN_OPT_ECHO) remote_echo = 1'b0;
          answer = TN_DONT;
        end else begin
          answer = TN_WONT;
        end
        tn_phase = TN_PLAIN;
        emit(DEST_NET, TN_IAC);
        emit(DEST_NET, answer);
        emit(DEST_NET, c);
      end
      default: begin
        tn_phase = TN_PLAIN;
        if (c == TN_IAC) begin
          tn_phase = TN_GOT_IAC;
        end else if (c == CH_NL) begin
          emit(DEST_SERIAL, CH_CR);
          emit(DEST_SERIAL, CH_NL);
        end else begin
          emit(DEST_SERIAL, c);
        end
      end
    endcase
  endfunction

  function automatic void predict_transfer(logic mode, logic [7:0] c);
    tx_byte_t t;
    burst_tx.delete();
    if (mode == SRC_SERIAL) edit_serial_byte(c);
    else parse_network_byte(c);
    if (burst_tx.size() != 0) begin
      t = burst_tx.pop_back();
      t.last = 1'b1;
      burst_tx.push_back(t);
    end
    foreach (burst_tx[i]) pending_tx.push_back(burst_tx[i]);
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    err_count++;
    if (err_count <= 100)
      $display("mismatch at cycle %0d: %s got %02h expected %02h", cycle_count, what, got,
               want);
  endtask

  // everything is stable between falling and rising edge, so sample here
  always @(negedge clk) begin
    tx_byte_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_transfer(in_mode, in_byte);
      if (out_valid && !out_stall) begin
        if (pending_tx.size() == 0) begin
          report_mismatch("output transfer with nothing expected, byte", out_byte, 8'h00);
        end else begin
          want = pending_tx.pop_front();
          if (out_dest !== want.dest)
            report_mismatch("out_dest", {7'b0, out_dest}, {7'b0, want.dest});
          if (out_byte !== want.data)
            report_mismatch("out_byte", out_byte, want.data);
          if (out_last !== want.last)
            report_mismatch("out_last", {7'b0, out_last}, {7'b0, want.last});
        end
      end
    end
  end

  task automatic send_item(logic mode, logic [7:0] b);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_byte <= b;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_telnet(logic [7:0] cmd, logic [7:0] opt);
    send_item(SRC_NET, TN_IAC);
    send_item(SRC_NET, cmd);
    send_item(SRC_NET, opt);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_tx.size() != 0);
  endtask

  function automatic logic [7:0] random_key();
    int p;
    p = $urandom_range(99);
    if (p < 60) return 8'($urandom_range(8'h7e, 8'h20));
    if (p < 68) return CH_CR;
    if (p < 72) return CH_NL;
    if (p < 82) return CH_DEL;
    if (p < 86) return CH_BS;
    if (p < 90) return CH_CTRL_R;
    return 8'($urandom_range(255));
  endfunction

  task automatic test_line_editing();
    send_item(SRC_SERIAL, 8'h68);
    send_item(SRC_SERIAL, CH_NUL);
    send_item(SRC_SERIAL, 8'hff);
    send_item(SRC_SERIAL, CH_DEL);
    send_item(SRC_SERIAL, CH_CTRL_R);
    send_item(SRC_SERIAL, CH_CR);
    // erase on an empty line stays silent
    send_item(SRC_SERIAL, CH_BS);
    send_item(SRC_SERIAL, CH_NL);
  endtask

  task automatic test_network_bytes();
    send_item(SRC_NET, 8'h41);
    send_item(SRC_NET, CH_NL);
    send_item(SRC_NET, TN_DONT);
    // doubled iac and a non-command after iac both end silently
    send_item(SRC_NET, TN_IAC);
    send_item(SRC_NET, TN_IAC);
    send_item(SRC_NET, TN_IAC);
    send_item(SRC_NET, TN_CMD_LOW);
  endtask

  task automatic test_echo_negotiation();
    send_telnet(TN_WILL, TN_OPT_ECHO);
    // remote echo: no editing, every byte goes straight out
    send_item(SRC_SERIAL, CH_CR);
    send_item(SRC_SERIAL, CH_DEL);
    send_telnet(TN_WONT, 8'h22);
    send_telnet(TN_DO, TN_OPT_ECHO);
    send_telnet(TN_WONT, TN_OPT_ECHO);
    send_telnet(TN_DONT, 8'hff);
    send_telnet(TN_WILL, 8'h03);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int pick;
    int run;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        run = $urandom_range(6, 1);
        repeat (run) send_item(SRC_SERIAL, random_key());
        sent += run;
      end else if (pick < 55) begin
        // fill a long line, then reprint it for the longest bursts
        if (remote_echo) begin
          send_telnet(TN_WONT, TN_OPT_ECHO);
          sent += 3;
        end
        run = $urandom_range(32, 20);
        repeat (run) send_item(SRC_SERIAL, 8'($urandom_range(8'h7e, 8'h20)));
        send_item(SRC_SERIAL, CH_CTRL_R);
        sent += run + 1;
      end else if (pick < 75) begin
        b = ($urandom_range(4) == 0) ? CH_NL : 8'($urandom_range(254));
        send_item(SRC_NET, b);
        sent++;
      end else if (pick < 92) begin
        b = ($urandom_range(1) == 0) ? TN_OPT_ECHO : 8'($urandom_range(255));
        send_telnet(8'($urandom_range(TN_DONT, TN_WILL)), b);
        sent += 3;
      end else begin
        // broken sequence: iac followed by anything
        send_item(SRC_NET, TN_IAC);
        send_item(SRC_NET, 8'($urandom_range(255)));
        sent += 2;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 30;
    recv_idle_pct = 69;
    test_line_editing();
    test_network_bytes();
    test_echo_negotiation();
    // hold off until every directed transfer has come out
    wait_drained();
    test_random_traffic(92);
    send_idle_pct = 69;
    recv_idle_pct = 30;
    test_random_traffic(92);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(92);
    wait_drained();
    repeat (END_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_terminal_session_line_bridge: clean");
    end else begin
      $display("tb_terminal_session_line_bridge: errors");
    end
    $finish;
  end

endmodule
